>>> sv/smc_pkg.sv
// ----------------------------------------------------------------------------
// smc_pkg
// types and opcode constants shared by the stack machine core
// ----------------------------------------------------------------------------
package smc_pkg;

	localparam int unsigned FIELD_ADDR_BITS = 18;

	typedef struct packed {
		logic [1:0]                 req_type;
		logic [FIELD_ADDR_BITS-1:0] mem_addr;
		logic signed [63:0]         write_value;
	} smc_in_t;

	typedef struct packed {
		logic signed [63:0]         read_value;
		logic [2:0]                 status;
		logic signed [63:0]         accumulator;
		logic [FIELD_ADDR_BITS-1:0] program_counter;
	} smc_out_t;

	localparam logic [1:0] REQ_WRITE = 2'd0;
	localparam logic [1:0] REQ_READ  = 2'd1;
	localparam logic [1:0] REQ_START = 2'd2;
	localparam logic [1:0] REQ_STEP  = 2'd3;

	localparam logic [2:0] ST_OK     = 3'd0;
	localparam logic [2:0] ST_EXIT   = 3'd1;
	localparam logic [2:0] ST_BADOP  = 3'd2;
	localparam logic [2:0] ST_DIVZ   = 3'd3;
	localparam logic [2:0] ST_HALTED = 3'd4;

	localparam logic [0:0] CFG_START_PC  = 1'd0;
	localparam logic [0:0] CFG_STACK_TOP = 1'd1;

	localparam logic [5:0] OP_LEA  = 6'd0;
	localparam logic [5:0] OP_IMM  = 6'd1;
	localparam logic [5:0] OP_JMP  = 6'd2;
	localparam logic [5:0] OP_CALL = 6'd3;
	localparam logic [5:0] OP_JZ   = 6'd4;
	localparam logic [5:0] OP_JNZ  = 6'd5;
	localparam logic [5:0] OP_ENT  = 6'd6;
	localparam logic [5:0] OP_ADJ  = 6'd7;
	localparam logic [5:0] OP_LEV  = 6'd8;
	localparam logic [5:0] OP_LI   = 6'd9;
	localparam logic [5:0] OP_LC   = 6'd10;
	localparam logic [5:0] OP_SI   = 6'd11;
	localparam logic [5:0] OP_SC   = 6'd12;
	localparam logic [5:0] OP_PUSH = 6'd13;
	localparam logic [5:0] OP_OR   = 6'd14;
	localparam logic [5:0] OP_XOR  = 6'd15;
	localparam logic [5:0] OP_AND  = 6'd16;
	localparam logic [5:0] OP_EQ   = 6'd17;
	localparam logic [5:0] OP_NE   = 6'd18;
	localparam logic [5:0] OP_LT   = 6'd19;
	localparam logic [5:0] OP_GT   = 6'd20;
	localparam logic [5:0] OP_LE   = 6'd21;
	localparam logic [5:0] OP_GE   = 6'd22;
	localparam logic [5:0] OP_SHL  = 6'd23;
	localparam logic [5:0] OP_SHR  = 6'd24;
	localparam logic [5:0] OP_ADD  = 6'd25;
	localparam logic [5:0] OP_SUB  = 6'd26;
	localparam logic [5:0] OP_MUL  = 6'd27;
	localparam logic [5:0] OP_DIV  = 6'd28;
	localparam logic [5:0] OP_MOD  = 6'd29;
	localparam logic [5:0] OP_EXIT = 6'd37;

endpackage

>>> sv/stack_machine_core.sv
// ----------------------------------------------------------------------------
// stack_machine_core
// one-accumulator stack machine over a word memory, one request per item
// ----------------------------------------------------------------------------
//  channel | signals                         | direction
//  req     | req_valid, req_ready, req_data  | in,  smc_in_t
//  rsp     | rsp_valid, rsp_ready, rsp_data  | out, smc_out_t
//  cfg     | cfg_valid, cfg_ready, cfg_index,| in,  register writes
//          | cfg_data                        |
//
// a write and a step while halted go straight to the response; a read waits for
// its memory data; a step makes its memory accesses in sequence, then responds;
// div, mod and mul run bit by bit in the shared shift/add unit
// reset: halted, pc 0, sp and bp at 2^ADDR_BITS, acc 0; memory not cleared
// one item at a time: req_ready is low from acceptance until the result is taken,
// so a low rsp_ready also holds off the next request
module stack_machine_core
	import smc_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_ready,
	input  smc_in_t   req_data,
	output logic      rsp_valid,
	input  logic      rsp_ready,
	output smc_out_t  rsp_data,
	input  logic      cfg_valid,
	output logic      cfg_ready,
	input  logic      cfg_index,
	input  logic [31:0] cfg_data
);

	localparam int unsigned ADDR_BITS = FIELD_ADDR_BITS;
	localparam int unsigned WA = ADDR_BITS - 3;	// word address bits
	localparam int unsigned SPB = ADDR_BITS + 1;

	// sequencer codes
	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_MEMRD = 4'd1;	// read data arriving
	localparam logic [3:0] S_FETCH = 4'd2;	// opcode arriving
	localparam logic [3:0] S_ARG   = 4'd3;	// immediate / target arriving
	localparam logic [3:0] S_LOAD  = 4'd4;	// li / lc / exit data arriving
	localparam logic [3:0] S_POP   = 4'd5;	// popped word arriving
	localparam logic [3:0] S_POP2  = 4'd6;	// second pop (lev)
	localparam logic [3:0] S_DIV   = 4'd7;	// iterative div / mod / mul
	localparam logic [3:0] S_DONE  = 4'd8;
	localparam logic [3:0] S_RESP  = 4'd9;
	localparam logic [3:0] S_PUSH2 = 4'd10;	// unused; ent pushes bp and adjusts in S_ARG
	localparam logic [3:0] S_SCWR  = 4'd11;	// byte store merge

	logic [3:0] state_q;

	logic [63:0] mem [2**WA];
	logic [63:0] rdata_q;
	logic        we;
	logic [WA-1:0] waddr, raddr;
	logic [63:0] wdata;
	logic        re;

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		if (re) rdata_q <= mem[raddr];
	end

	logic [ADDR_BITS-1:0] pc_q, start_pc_q;
	logic [SPB-1:0]       sp_q, bp_q, stack_top_q;
	logic [63:0]          acc_q, a_q, rv_q;
	logic [5:0]           op_q;
	logic [2:0]           st_q;
	logic                 halted_q;
	logic [63:0]          stad_q;	// store address held for sc

	// shared iterative unit
	logic [63:0] quo_q, rem_q, dvs_q;
	logic [6:0]  dcnt_q;
	logic [64:0] rem_sh;
	assign rem_sh = {rem_q, quo_q[63]};

	logic [63:0] a_mag, b_mag;
	assign a_mag = rdata_q[63] ? 64'(-rdata_q) : rdata_q;
	assign b_mag = acc_q[63] ? 64'(-acc_q) : acc_q;

	assign req_ready = (state_q == S_IDLE);
	assign cfg_ready = (state_q == S_IDLE);
	assign rsp_valid = (state_q == S_RESP);
	assign rsp_data.read_value = rv_q;
	assign rsp_data.status = st_q;
	assign rsp_data.accumulator = acc_q;
	assign rsp_data.program_counter = pc_q;

	function automatic logic [WA-1:0] wadr(input logic [63:0] a);
		return a[ADDR_BITS-1:3];
	endfunction

	// binary operation on popped word and acc
	logic [63:0] alu;
	logic [7:0]  lc_byte;
	always_comb begin
		alu = acc_q;
		case (op_q)
			OP_OR:  alu = rdata_q | acc_q;
			OP_XOR: alu = rdata_q ^ acc_q;
			OP_AND: alu = rdata_q & acc_q;
			OP_EQ:  alu = {63'd0, rdata_q == acc_q};
			OP_NE:  alu = {63'd0, rdata_q != acc_q};
			OP_LT:  alu = {63'd0, $signed(rdata_q) < $signed(acc_q)};
			OP_GT:  alu = {63'd0, $signed(acc_q) < $signed(rdata_q)};
			OP_LE:  alu = {63'd0, !($signed(acc_q) < $signed(rdata_q))};
			OP_GE:  alu = {63'd0, !($signed(rdata_q) < $signed(acc_q))};
			OP_SHL: alu = rdata_q << acc_q[5:0];
			OP_SHR: alu = 64'($signed(rdata_q) >>> acc_q[5:0]);
			OP_ADD: alu = rdata_q + acc_q;
			OP_SUB: alu = rdata_q - acc_q;
			default: alu = acc_q;
		endcase
		lc_byte = rdata_q[acc_q[2:0]*8 +: 8];
	end

	always_comb begin
		we = 1'b0; waddr = '0; wdata = '0; re = 1'b0; raddr = '0;
		if (state_q == S_IDLE && req_valid) begin
			if (req_data.req_type == REQ_WRITE) begin
				we = 1'b1;
				waddr = req_data.mem_addr[ADDR_BITS-1:3];
				wdata = req_data.write_value;
			end else if (req_data.req_type == REQ_READ) begin
				re = 1'b1;
				raddr = req_data.mem_addr[ADDR_BITS-1:3];
			end else if (req_data.req_type == REQ_STEP && !halted_q) begin
				re = 1'b1;
				raddr = pc_q[ADDR_BITS-1:3];
			end
		end else if (state_q == S_FETCH && rdata_q[63:6] == '0) begin
			re = 1'b1;
			case (rdata_q[5:0])
				OP_LI, OP_LC: raddr = wadr(acc_q);
				OP_EXIT:      raddr = wadr(64'(sp_q));
				OP_PUSH: begin
					re = 1'b0; we = 1'b1;
					waddr = wadr(64'(SPB'(sp_q - SPB'(8))));
					wdata = acc_q;
				end
				OP_LEA, OP_IMM, OP_JMP, OP_CALL, OP_JZ, OP_JNZ, OP_ENT, OP_ADJ:
					raddr = pc_q[ADDR_BITS-1:3];
				OP_LEV: raddr = wadr(64'(bp_q));
				default: raddr = wadr(64'(sp_q));
			endcase
		end else if (state_q == S_ARG) begin
			if (op_q == OP_CALL) begin
				we = 1'b1;
				waddr = wadr(64'(SPB'(sp_q - SPB'(8))));
				wdata = 64'(ADDR_BITS'(pc_q + ADDR_BITS'(8)));
			end else if (op_q == OP_ENT) begin
				we = 1'b1;
				waddr = wadr(64'(SPB'(sp_q - SPB'(8))));
				wdata = 64'(bp_q);
			end
		end else if (state_q == S_POP) begin
			if (op_q == OP_SI) begin
				we = 1'b1; waddr = wadr(rdata_q); wdata = acc_q;
			end else if (op_q == OP_SC) begin
				re = 1'b1; raddr = wadr(rdata_q);
			end else if (op_q == OP_LEV) begin
				// return address sits one word above the saved bp
				re = 1'b1; raddr = wadr(64'(SPB'(sp_q + SPB'(8))));
			end
		end else if (state_q == S_SCWR) begin
			we = 1'b1; waddr = wadr(stad_q);
			wdata = rdata_q;
			wdata[stad_q[2:0]*8 +: 8] = acc_q[7:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			pc_q <= '0;
			sp_q <= SPB'(1) << ADDR_BITS;
			bp_q <= SPB'(1) << ADDR_BITS;
			acc_q <= '0;
			halted_q <= 1'b1;
			start_pc_q <= '0;
			stack_top_q <= SPB'(1) << ADDR_BITS;
			st_q <= ST_OK;
			rv_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (cfg_valid) begin
						if (cfg_index == CFG_START_PC) start_pc_q <= cfg_data[ADDR_BITS-1:0];
						else stack_top_q <= cfg_data[SPB-1:0];
					end
					if (req_valid) begin
						rv_q <= '0;
						st_q <= ST_OK;
						case (req_data.req_type)
							REQ_WRITE: state_q <= S_RESP;
							REQ_READ:  state_q <= S_MEMRD;
							REQ_START: begin
								pc_q <= start_pc_q; sp_q <= stack_top_q;
								bp_q <= stack_top_q; acc_q <= '0;
								halted_q <= 1'b0; state_q <= S_RESP;
							end
							default: begin
								if (halted_q) begin
									st_q <= ST_HALTED; state_q <= S_RESP;
								end else begin
									pc_q <= ADDR_BITS'(pc_q + ADDR_BITS'(8));
									state_q <= S_FETCH;
								end
							end
						endcase
					end
				end
				S_MEMRD: begin
					rv_q <= rdata_q; state_q <= S_RESP;
				end
				S_FETCH: begin
					op_q <= rdata_q[5:0];
					if (rdata_q[63:6] != '0) begin
						st_q <= ST_BADOP; halted_q <= 1'b1; state_q <= S_RESP;
					end else begin
						case (rdata_q[5:0])
							OP_LI, OP_LC: state_q <= S_LOAD;
							OP_EXIT: state_q <= S_LOAD;
							OP_PUSH: begin
								sp_q <= SPB'(sp_q - SPB'(8)); state_q <= S_RESP;
							end
							OP_LEA, OP_IMM, OP_JMP, OP_CALL, OP_JZ, OP_JNZ, OP_ENT, OP_ADJ:
								state_q <= S_ARG;
							OP_LEV: begin
								sp_q <= bp_q; state_q <= S_POP;
							end
							OP_SI, OP_SC, OP_OR, OP_XOR, OP_AND, OP_EQ, OP_NE, OP_LT,
							OP_GT, OP_LE, OP_GE, OP_SHL, OP_SHR, OP_ADD, OP_SUB, OP_MUL:
								state_q <= S_POP;
							OP_DIV, OP_MOD: begin
								if (acc_q == '0) begin
									st_q <= ST_DIVZ; halted_q <= 1'b1; state_q <= S_RESP;
								end else state_q <= S_POP;
							end
							default: begin
								st_q <= ST_BADOP; halted_q <= 1'b1; state_q <= S_RESP;
							end
						endcase
					end
				end
				S_ARG: begin
					state_q <= S_RESP;
					case (op_q)
						OP_IMM: begin
							acc_q <= rdata_q; pc_q <= ADDR_BITS'(pc_q + ADDR_BITS'(8));
						end
						OP_LEA: begin
							acc_q <= 64'(SPB'(bp_q + SPB'({rdata_q, 3'd0})));
							pc_q <= ADDR_BITS'(pc_q + ADDR_BITS'(8));
						end
						OP_ADJ: begin
							sp_q <= SPB'(sp_q + SPB'({rdata_q, 3'd0}));
							pc_q <= ADDR_BITS'(pc_q + ADDR_BITS'(8));
						end
						OP_ENT: begin
							bp_q <= SPB'(sp_q - SPB'(8));
							sp_q <= SPB'(sp_q - SPB'(8) - SPB'({rdata_q, 3'd0}));
							pc_q <= ADDR_BITS'(pc_q + ADDR_BITS'(8));
						end
						OP_CALL: begin
							sp_q <= SPB'(sp_q - SPB'(8));
							pc_q <= rdata_q[ADDR_BITS-1:0];
						end
						OP_JMP: pc_q <= rdata_q[ADDR_BITS-1:0];
						OP_JZ: pc_q <= (acc_q == '0) ? rdata_q[ADDR_BITS-1:0]
							: ADDR_BITS'(pc_q + ADDR_BITS'(8));
						default: pc_q <= (acc_q != '0) ? rdata_q[ADDR_BITS-1:0]
							: ADDR_BITS'(pc_q + ADDR_BITS'(8));
					endcase
				end
				S_LOAD: begin
					state_q <= S_RESP;
					if (op_q == OP_LI) acc_q <= rdata_q;
					else if (op_q == OP_LC) acc_q <= {{56{lc_byte[7]}}, lc_byte};
					else begin
						rv_q <= rdata_q; st_q <= ST_EXIT; halted_q <= 1'b1;
					end
				end
				S_POP: begin
					sp_q <= SPB'(sp_q + SPB'(8));
					case (op_q)
						OP_SI: state_q <= S_RESP;
						OP_SC: begin
							stad_q <= rdata_q; state_q <= S_SCWR;
						end
						OP_LEV: begin
							bp_q <= rdata_q[SPB-1:0]; state_q <= S_POP2;
						end
						OP_DIV, OP_MOD: begin
							a_q <= rdata_q;
							quo_q <= a_mag; rem_q <= '0; dvs_q <= b_mag;
							dcnt_q <= 7'd64; state_q <= S_DIV;
						end
						OP_MUL: begin
							// multiplier in quo, multiplicand in dvs, product in rem
							quo_q <= rdata_q; rem_q <= '0; dvs_q <= acc_q;
							dcnt_q <= 7'd64; state_q <= S_DIV;
						end
						default: begin
							acc_q <= alu; state_q <= S_RESP;
						end
					endcase
				end
				S_POP2: begin
					sp_q <= SPB'(sp_q + SPB'(8));
					pc_q <= rdata_q[ADDR_BITS-1:0];
					state_q <= S_RESP;
				end
				S_SCWR: state_q <= S_RESP;
				S_DIV: begin
					// one bit a cycle: shift-and-add multiply or restoring division
					if (dcnt_q != '0) begin
						if (op_q == OP_MUL) begin
							if (quo_q[0]) rem_q <= rem_q + dvs_q;
							quo_q <= {1'b0, quo_q[63:1]};
							dvs_q <= {dvs_q[62:0], 1'b0};
						end else if (rem_sh >= {1'b0, dvs_q}) begin
							rem_q <= 64'(rem_sh - {1'b0, dvs_q});
							quo_q <= {quo_q[62:0], 1'b1};
						end else begin
							rem_q <= rem_sh[63:0];
							quo_q <= {quo_q[62:0], 1'b0};
						end
						dcnt_q <= dcnt_q - 7'd1;
					end else state_q <= S_DONE;
				end
				S_DONE: begin
					if (op_q == OP_DIV)
						acc_q <= (a_q[63] ^ acc_q[63]) ? 64'(-quo_q) : quo_q;
					else if (op_q == OP_MOD)
						acc_q <= a_q[63] ? 64'(-rem_q) : rem_q;
					else
						acc_q <= rem_q;
					state_q <= S_RESP;
				end
				S_RESP: if (rsp_ready) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

>>> verif/stack_machine_core_test.sv
// ----------------------------------------------------------------------------
// stack_machine_core_test
// self-checking bench: generated programs with random content run through the
// core; a shadow copy of the machine predicts every response item
// ----------------------------------------------------------------------------
module stack_machine_core_test
	import smc_pkg::*;
;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int DRAIN_CYCLES   = 120;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        req_valid = 1'b0;
	logic        req_ready;
	smc_in_t     req_data = '0;
	logic        rsp_valid;
	logic        rsp_ready = 1'b0;
	smc_out_t    rsp_data;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic        cfg_index = 1'b0;
	logic [31:0] cfg_data = '0;

	smc_in_t  req_backlog[$];
	smc_out_t expected_rsp[$];
	int       errors = 0;
	int unsigned sent_items = 0;
	bit       calm = 1'b0;

	// shadow machine state
	logic [63:0] shadow_mem[int unsigned];
	int unsigned written_words[$];
	logic [17:0] sh_pc, sh_start_pc;
	logic [18:0] sh_sp, sh_bp, sh_stack_top;
	logic [63:0] sh_acc;
	bit          sh_halted;

	stack_machine_core dut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
		.rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #10 clk = ~clk;

	// ---------------- shadow memory and stack ----------------
	function automatic logic [63:0] word_rd(logic [17:0] a);
		return shadow_mem.exists(a[17:3]) ? shadow_mem[a[17:3]] : 64'd0;
	endfunction

	function automatic void word_wr(logic [17:0] a, logic [63:0] v);
		if (!shadow_mem.exists(a[17:3]))
			written_words.push_back(a[17:3]);
		shadow_mem[a[17:3]] = v;
	endfunction

	function automatic logic [63:0] fetch_word();
		logic [63:0] v;
		v = word_rd(sh_pc);
		sh_pc = sh_pc + 18'd8;
		return v;
	endfunction

	function automatic logic [63:0] pop_word();
		logic [63:0] v;
		v = word_rd(sh_sp[17:0]);
		sh_sp = sh_sp + 19'd8;
		return v;
	endfunction

	function automatic void push_word(logic [63:0] v);
		sh_sp = sh_sp - 19'd8;
		word_wr(sh_sp[17:0], v);
	endfunction

	function automatic logic [63:0] magnitude(logic [63:0] v);
		return v[63] ? -v : v;
	endfunction

	// one instruction at pc; returns the status it ends with
	function automatic logic [2:0] run_instruction(output logic [63:0] rv);
		logic [63:0] op, a, n, w;
		int unsigned sh;
		rv = '0;
		op = fetch_word();
		case (op)
			OP_IMM: sh_acc = fetch_word();
			OP_LC: begin
				w = word_rd(sh_acc[17:0]);
				sh = sh_acc[2:0] * 8;
				a = w >> sh;
				sh_acc = {{56{a[7]}}, a[7:0]};
			end
			OP_LI: sh_acc = word_rd(sh_acc[17:0]);
			OP_SC: begin
				a = pop_word();
				w = word_rd(a[17:0]);
				sh = a[2:0] * 8;
				w = (w & ~(64'hFF << sh)) | ({56'd0, sh_acc[7:0]} << sh);
				word_wr(a[17:0], w);
			end
			OP_SI: begin
				a = pop_word();
				word_wr(a[17:0], sh_acc);
			end
			OP_PUSH: push_word(sh_acc);
			OP_JMP: sh_pc = 18'(word_rd(sh_pc));
			OP_JZ:  sh_pc = (sh_acc == 0) ? 18'(word_rd(sh_pc)) : sh_pc + 18'd8;
			OP_JNZ: sh_pc = (sh_acc != 0) ? 18'(word_rd(sh_pc)) : sh_pc + 18'd8;
			OP_CALL: begin
				push_word(64'(sh_pc + 18'd8));
				sh_pc = 18'(word_rd(sh_pc));
			end
			OP_ENT: begin
				n = fetch_word();
				push_word(64'(sh_bp));
				sh_bp = sh_sp;
				sh_sp = sh_sp - 19'(n << 3);
			end
			OP_ADJ: begin
				n = fetch_word();
				sh_sp = sh_sp + 19'(n << 3);
			end
			OP_LEV: begin
				sh_sp = sh_bp;
				sh_bp = 19'(pop_word());
				sh_pc = 18'(pop_word());
			end
			OP_LEA: begin
				n = fetch_word();
				sh_acc = 64'(sh_bp + 19'(n << 3));
			end
			OP_OR:  sh_acc = pop_word() | sh_acc;
			OP_XOR: sh_acc = pop_word() ^ sh_acc;
			OP_AND: sh_acc = pop_word() & sh_acc;
			OP_EQ:  sh_acc = (pop_word() == sh_acc) ? 64'd1 : 64'd0;
			OP_NE:  sh_acc = (pop_word() != sh_acc) ? 64'd1 : 64'd0;
			OP_LT: begin
				a = pop_word(); sh_acc = ($signed(a) <  $signed(sh_acc)) ? 64'd1 : 64'd0;
			end
			OP_GT: begin
				a = pop_word(); sh_acc = ($signed(a) >  $signed(sh_acc)) ? 64'd1 : 64'd0;
			end
			OP_LE: begin
				a = pop_word(); sh_acc = ($signed(a) <= $signed(sh_acc)) ? 64'd1 : 64'd0;
			end
			OP_GE: begin
				a = pop_word(); sh_acc = ($signed(a) >= $signed(sh_acc)) ? 64'd1 : 64'd0;
			end
			OP_SHL: begin a = pop_word(); sh_acc = a << sh_acc[5:0]; end
			OP_SHR: begin a = pop_word(); sh_acc = 64'($signed(a) >>> sh_acc[5:0]); end
			OP_ADD: sh_acc = pop_word() + sh_acc;
			OP_SUB: begin a = pop_word(); sh_acc = a - sh_acc; end
			OP_MUL: sh_acc = pop_word() * sh_acc;
			OP_DIV, OP_MOD: begin
				if (sh_acc == 0)
					return ST_DIVZ;
				a = pop_word();
				if (op == OP_DIV) begin
					n = magnitude(a) / magnitude(sh_acc);
					sh_acc = (a[63] ^ sh_acc[63]) ? -n : n;
				end else begin
					n = magnitude(a) % magnitude(sh_acc);
					sh_acc = a[63] ? -n : n;
				end
			end
			OP_EXIT: begin
				rv = word_rd(sh_sp[17:0]);
				return ST_EXIT;
			end
			default: return ST_BADOP;
		endcase
		return ST_OK;
	endfunction

	function automatic smc_out_t model_request(smc_in_t it);
		smc_out_t r;
		r = '0;
		r.status = ST_OK;
		case (it.req_type)
			REQ_WRITE: word_wr(it.mem_addr, it.write_value);
			REQ_READ:  r.read_value = word_rd(it.mem_addr);
			REQ_START: begin
				sh_pc = sh_start_pc;
				sh_sp = sh_stack_top;
				sh_bp = sh_stack_top;
				sh_acc = '0;
				sh_halted = 1'b0;
			end
			default: begin
				if (sh_halted) begin
					r.status = ST_HALTED;
				end else begin
					r.status = run_instruction(r.read_value);
					if (r.status != ST_OK)
						sh_halted = 1'b1;
				end
			end
		endcase
		r.accumulator = sh_acc;
		r.program_counter = sh_pc;
		return r;
	endfunction

	// ---------------- stimulus helpers ----------------
	function automatic logic [63:0] rand_data();
		case ($urandom_range(0, 7))
			0: return 64'd0;
			1: return '1;
			2: return 64'h8000_0000_0000_0000;
			3: return 64'h7FFF_FFFF_FFFF_FFFF;
			4: return 64'($urandom_range(0, 70));
			5: return -64'($urandom_range(1, 70));
			default: return {$urandom, $urandom};
		endcase
	endfunction

	function automatic logic [63:0] pick_opcode();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 2)
			return 64'($urandom_range(30, 36));
		if (r < 4)
			return {$urandom, $urandom};
		if (r < 8)
			return 64'(OP_EXIT);
		return 64'($urandom_range(0, 29));
	endfunction

	function automatic logic [63:0] pick_operand(logic [63:0] op);
		logic [63:0] v;
		if (op == OP_ENT || op == OP_ADJ)
			return ($urandom_range(0, 9) == 0) ? {$urandom, $urandom}
				: 64'($urandom_range(0, 6));
		if (op == OP_JMP || op == OP_JZ || op == OP_JNZ || op == OP_CALL) begin
			// land near the start of the code, upper bits are ignored
			v = {$urandom, $urandom};
			v[17:0] = sh_start_pc + 18'($urandom_range(0, 255) * 8);
			return v;
		end
		return rand_data();
	endfunction

	task automatic put_item(logic [1:0] kind, logic [17:0] a, logic [63:0] v);
		smc_in_t it;
		it.req_type = kind;
		it.mem_addr = a;
		it.write_value = v;
		req_backlog.push_back(it);
		expected_rsp.push_back(model_request(it));
		sent_items++;
	endtask

	// write a word only where nothing has been written yet
	task automatic fill_word(logic [17:0] a, logic [63:0] v);
		if (!shadow_mem.exists(a[17:3]))
			put_item(REQ_WRITE, {a[17:3], 3'($urandom)}, v);
	endtask

	// make sure every word the next instruction reads exists, then step
	task automatic step_item();
		logic [63:0] op;
		if (!sh_halted) begin
			fill_word(sh_pc, pick_opcode());
			op = word_rd(sh_pc);
			if (op == OP_IMM || op == OP_JMP || op == OP_JZ || op == OP_JNZ
				|| op == OP_CALL || op == OP_ENT || op == OP_ADJ || op == OP_LEA)
				fill_word(sh_pc + 18'd8, pick_operand(op));
			if (op == OP_SI || op == OP_SC || op == OP_EXIT
				|| (op >= OP_OR && op <= OP_MOD))
				fill_word(sh_sp[17:0], rand_data());
			if (op == OP_SC)
				fill_word(18'(word_rd(sh_sp[17:0])), rand_data());
			if (op == OP_LI || op == OP_LC)
				fill_word(sh_acc[17:0], rand_data());
			if (op == OP_LEV) begin
				fill_word(sh_bp[17:0], rand_data());
				fill_word(18'(sh_bp + 19'd8), rand_data());
			end
		end
		put_item(REQ_STEP, 18'($urandom), {$urandom, $urandom});
	endtask

	task automatic read_item();
		int unsigned w;
		if (written_words.size() == 0)
			return;
		w = written_words[$urandom_range(0, written_words.size() - 1)];
		put_item(REQ_READ, {w[14:0], 3'($urandom)}, {$urandom, $urandom});
	endtask

	task automatic wait_idle();
		while (req_backlog.size() != 0 || expected_rsp.size() != 0)
			@(posedge clk);
		// every response is taken by now; no divide is still running in the core
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_register(logic idx, logic [31:0] d);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= d;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		if (idx == CFG_START_PC)
			sh_start_pc = d[17:0];
		else
			sh_stack_top = d[18:0];
		@(posedge clk);
	endtask

	// ---------------- stimulus ----------------
	initial begin
		logic [31:0] pc_val, top_val;
		int unsigned r;
		int unsigned base;
		sh_pc = '0; sh_start_pc = '0; sh_acc = '0; sh_halted = 1'b1;
		sh_sp = 19'h40000; sh_bp = 19'h40000; sh_stack_top = 19'h40000;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: address extremes, step before any start, then
		// most negative mod -1, a push-divide chain and a divide by zero
		put_item(REQ_WRITE, 18'h3FFFF, '1);
		put_item(REQ_WRITE, 18'h00000, 64'd0);
		put_item(REQ_READ, 18'h3FFF8, '0);
		put_item(REQ_READ, 18'h00007, '1);
		put_item(REQ_STEP, 18'h3FFFF, '1);
		put_item(REQ_WRITE, 18'd0,  64'(OP_IMM));
		put_item(REQ_WRITE, 18'd8,  64'h8000_0000_0000_0000);
		put_item(REQ_WRITE, 18'd16, 64'(OP_PUSH));
		put_item(REQ_WRITE, 18'd24, 64'(OP_IMM));
		put_item(REQ_WRITE, 18'd32, '1);
		put_item(REQ_WRITE, 18'd40, 64'(OP_MOD));
		put_item(REQ_WRITE, 18'd48, 64'(OP_PUSH));
		put_item(REQ_WRITE, 18'd56, 64'(OP_IMM));
		put_item(REQ_WRITE, 18'd64, 64'd0);
		put_item(REQ_WRITE, 18'd72, 64'(OP_DIV));
		put_item(REQ_START, '0, '0);
		repeat (7) put_item(REQ_STEP, '0, '0);
		put_item(REQ_STEP, '0, '0);

		for (int phase = 0; phase < 5; phase++) begin
			wait_idle();
			case (phase)
				0: begin pc_val = 32'd0;      top_val = 32'h40000; end
				1: begin pc_val = 32'h3FFFF;  top_val = 32'd0;     end
				default: begin
					pc_val = $urandom_range(0, 32'h3FFFF);
					top_val = $urandom_range(0, 32'h40000);
				end
			endcase
			// upper bits of the data bus are don't-care, toggle them
			write_register(CFG_START_PC, pc_val | ($urandom & ~32'h3FFFF));
			write_register(CFG_STACK_TOP, top_val | ($urandom & ~32'h7FFFF));
			calm = (phase == 2);
			base = sent_items;
			put_item(REQ_START, 18'($urandom), {$urandom, $urandom});
			while (sent_items - base < 300) begin
				r = $urandom_range(0, 99);
				if (sh_halted) begin
					if (r < 65)      put_item(REQ_START, 18'($urandom), rand_data());
					else if (r < 78) step_item();
					else if (r < 90) put_item(REQ_WRITE, 18'($urandom), rand_data());
					else             read_item();
				end else begin
					if (r < 82)      step_item();
					else if (r < 89) put_item(REQ_WRITE, 18'($urandom), rand_data());
					else if (r < 97) read_item();
					else             put_item(REQ_START, 18'($urandom), rand_data());
				end
			end
		end

		wait_idle();
		if (errors == 0)
			$display("stack_machine_core_test: done, clean");
		else
			$display("stack_machine_core_test: done, errors");
		$finish;
	end

	// ---------------- request driver ----------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
		end else if (!req_valid || req_ready) begin
			if (req_backlog.size() != 0 && (calm || $urandom_range(0, 99) >= 32)) begin
				req_valid <= 1'b1;
				req_data  <= req_backlog.pop_front();
			end else begin
				req_valid <= 1'b0;
			end
		end
	end

	// ---------------- response monitor ----------------
	task automatic report(string what, logic [63:0] got, logic [63:0] want);
		$display("mismatch %s: got %h want %h", what, got, want);
		errors++;
	endtask

	int unsigned mon_cycles = 0;
	int unsigned hold_off = 0;

	always @(posedge clk or negedge arst_n) begin
		smc_out_t want;
		if (!arst_n) begin
			rsp_ready <= 1'b0;
		end else begin
			mon_cycles <= mon_cycles + 1;
			if (rsp_valid && rsp_ready) begin
				if (expected_rsp.size() == 0) begin
					report("unexpected item", rsp_data.read_value, '0);
				end else begin
					want = expected_rsp.pop_front();
					if (rsp_data.read_value !== want.read_value)
						report("read_value", rsp_data.read_value, want.read_value);
					if (rsp_data.status !== want.status)
						report("status", 64'(rsp_data.status), 64'(want.status));
					if (rsp_data.accumulator !== want.accumulator)
						report("accumulator", rsp_data.accumulator, want.accumulator);
					if (rsp_data.program_counter !== want.program_counter)
						report("program_counter", 64'(rsp_data.program_counter),
							64'(want.program_counter));
				end
			end
			// one long back-pressure stretch so the core stalls its input
			if (mon_cycles == 3000) begin
				hold_off <= 600;
				rsp_ready <= 1'b0;
			end else if (hold_off != 0) begin
				hold_off <= hold_off - 1;
				rsp_ready <= 1'b0;
			end else begin
				rsp_ready <= calm || ($urandom_range(0, 99) >= 32);
			end
		end
	end

	// ---------------- watchdog ----------------
	int unsigned quiet_cycles = 0;

	always @(posedge clk) begin
		if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles == WATCHDOG_LIMIT) begin
			$display("stack_machine_core_test: done, errors");
			$finish;
		end
	end

endmodule
